// ===== rtl/core/mrd_pkg.sv =====
// Package for the memory region decoder: operation and status codes,
// request and chain structs shared by the top level and the slot cells.
// No dependencies.
package mrd_pkg;

  localparam int NUM_REGIONS_DEF = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_ACCESS = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERLAP   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [6:0] ACC_SIZE_MASK = 7'h7F;

  // One request as broadcast to every cell.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] rsize;
    logic [7:0]  hnd;
    logic [6:0]  asize;
    logic        wr;
  } req_t;

  // Handed from cell to cell in slot order.
  typedef struct packed {
    logic       ovl;
    logic       taken;
    logic [7:0] hnd;
  } chain_t;

  // Table update strobes for the transfer being committed.
  typedef struct packed {
    logic add_en;
    logic del_en;
  } wr_ctl_t;

endpackage

// ===== rtl/core/memory_region_decoder.sv =====
// Top level of the memory region decoder: request register, a chain of
// NUM_REGIONS slot cells and the result register. Depends on mrd_pkg, mrd_cell.
//
// Usage: each input transfer carries one operation: add a region (base,
// size, handler), delete a region (base and size must match), or decode an
// access address. Every input transfer yields exactly one result transfer
// with a status, the slot used and, for an access hit, the handler and the
// forwarded address, access size and write flag.
// Path: the result passes through the request register, the registered
// compare in every cell and the result register. A new input is not taken
// while the previous one is in the compare stage. The priority chain through
// all cells writes the table, so the next operation sees the updated table.
// A stalled receiver holds the result register; the block then takes at most
// one more input and parks it until the result register frees up.
// Reset (synchronous, active low) frees all slots and clears the bases;
// no clearing pass is needed.
module memory_region_decoder #(
  parameter int NUM_REGIONS = mrd_pkg::NUM_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_addr,
  input  logic [31:0] in_region_size,
  input  logic [7:0]  in_handler_in,
  input  logic [6:0]  in_access_size,
  input  logic        in_write_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [7:0]  out_handler_out,
  output logic [31:0] out_addr_out,
  output logic [6:0]  out_size_out,
  output logic        out_write_out
);

  localparam int IW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

  mrd_pkg::req_t    req_r;
  logic [32:0]      req_end;
  logic             v1_r, v1_nxt, v2_r, v2_nxt;
  logic             ov_r, ov_nxt;
  logic             commit, in_xfer;
  mrd_pkg::wr_ctl_t wr;
  mrd_pkg::chain_t  ch [0:NUM_REGIONS];
  logic [IW-1:0]    idx [0:NUM_REGIONS];

  logic [1:0]  st_nxt;
  logic [3:0]  slot_nxt;
  logic [7:0]  hnd_nxt;
  logic [31:0] addr_nxt;
  logic [6:0]  size_nxt;
  logic        wrf_nxt;
  logic [1:0]  st_r;
  logic [3:0]  slot_r;
  logic [7:0]  hnd_r;
  logic [31:0] addr_r;
  logic [6:0]  size_r;
  logic        wrf_r;

  // Stage two commits when the result register is free or draining
  assign commit   = v2_r && (!ov_r || out_ready);
  assign in_ready = !v1_r && (!v2_r || commit);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    v1_nxt = in_xfer;
    v2_nxt = v1_r | (v2_r & !commit);
    ov_nxt = commit | (ov_r & !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Hold the request until the next transfer; it is read by both stages
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r.op    <= in_op;
      req_r.addr  <= in_addr;
      req_r.rsize <= in_region_size;
      req_r.hnd   <= in_handler_in;
      req_r.asize <= in_access_size;
      req_r.wr    <= in_write_flag;
    end
  end

  assign req_end = {1'b0, req_r.addr} + {1'b0, req_r.rsize};

  assign ch[0]  = '0;
  assign idx[0] = '0;

  always_comb begin
    wr.add_en = commit && (req_r.op == mrd_pkg::OP_ADD) && !ch[NUM_REGIONS].ovl;
    wr.del_en = commit && (req_r.op == mrd_pkg::OP_DELETE);
  end

  for (genvar k = 0; k < NUM_REGIONS; k++) begin : g_cell
    mrd_cell #(
      .IW  (IW),
      .IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req_r),
      .req_end (req_end),
      .s1_en   (v1_r),
      .wr      (wr),
      .cin     (ch[k]),
      .idx_in  (idx[k]),
      .cout    (ch[k+1]),
      .idx_out (idx[k+1])
    );
  end

  always_comb begin
    st_nxt   = mrd_pkg::ST_NOT_FOUND;
    slot_nxt = 4'd0;
    hnd_nxt  = 8'd0;
    addr_nxt = 32'd0;
    size_nxt = 7'd0;
    wrf_nxt  = 1'b0;
    case (req_r.op)
      mrd_pkg::OP_ADD: begin
        if (ch[NUM_REGIONS].ovl) begin
          st_nxt = mrd_pkg::ST_OVERLAP;
        end else if (ch[NUM_REGIONS].taken) begin
          st_nxt   = mrd_pkg::ST_OK;
          slot_nxt = 4'(idx[NUM_REGIONS]);
        end else begin
          st_nxt = mrd_pkg::ST_FULL;
        end
      end
      mrd_pkg::OP_DELETE: begin
        if (ch[NUM_REGIONS].taken) begin
          st_nxt   = mrd_pkg::ST_OK;
          slot_nxt = 4'(idx[NUM_REGIONS]);
        end
      end
      mrd_pkg::OP_ACCESS: begin
        if (ch[NUM_REGIONS].taken) begin
          st_nxt   = mrd_pkg::ST_OK;
          slot_nxt = 4'(idx[NUM_REGIONS]);
          hnd_nxt  = ch[NUM_REGIONS].hnd;
          addr_nxt = req_r.addr;
          size_nxt = req_r.asize & mrd_pkg::ACC_SIZE_MASK;
          wrf_nxt  = req_r.wr;
        end
      end
      default: begin
        st_nxt = mrd_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      st_r   <= st_nxt;
      slot_r <= slot_nxt;
      hnd_r  <= hnd_nxt;
      addr_r <= addr_nxt;
      size_r <= size_nxt;
      wrf_r  <= wrf_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_slot        = slot_r;
  assign out_handler_out = hnd_r;
  assign out_addr_out    = addr_r;
  assign out_size_out    = size_r;
  assign out_write_out   = wrf_r;

endmodule

// ===== rtl/core/mrd_cell.sv =====
// One table slot of the memory region decoder: holds base, length and
// handler, compares against the broadcast request and joins the priority chain.
// Depends on mrd_pkg.
module mrd_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mrd_pkg::req_t   req,
  input  logic [32:0]     req_end,
  input  logic            s1_en,
  input  mrd_pkg::wr_ctl_t wr,
  input  mrd_pkg::chain_t cin,
  input  logic [IW-1:0]   idx_in,
  output mrd_pkg::chain_t cout,
  output logic [IW-1:0]   idx_out
);

  logic [31:0] base_r, base_nxt;
  logic [31:0] len_r, len_nxt;
  logic [7:0]  hnd_r, hnd_nxt;
  logic        ovl_r, free_r, del_r, hit_r;
  logic        used, inside_a, ovl_c;
  logic [32:0] cell_end;
  logic        sel_flag, selected;

  // Stage one: compares against the request
  always_comb begin
    cell_end = {1'b0, base_r} + {1'b0, len_r};
    used     = (len_r != 32'd0);
    inside_a = (base_r <= req.addr) && (cell_end > {1'b0, req.addr});
    ovl_c    = used && (inside_a ||
               ((req.addr <= base_r) && (req_end > {1'b0, base_r})));
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      ovl_r  <= ovl_c;
      free_r <= !used;
      del_r  <= (base_r == req.addr) && (len_r == req.rsize);
      hit_r  <= used && inside_a;
    end
  end

  // Stage two: first matching slot wins
  always_comb begin
    case (req.op)
      mrd_pkg::OP_ADD:    sel_flag = free_r;
      mrd_pkg::OP_DELETE: sel_flag = del_r;
      mrd_pkg::OP_ACCESS: sel_flag = hit_r;
      default:            sel_flag = 1'b0;
    endcase
    selected   = sel_flag && !cin.taken;
    cout.ovl   = cin.ovl | ovl_r;
    cout.taken = cin.taken | sel_flag;
    cout.hnd   = selected ? hnd_r : cin.hnd;
    idx_out    = selected ? IW'(IDX) : idx_in;
  end

  always_comb begin
    base_nxt = base_r;
    len_nxt  = len_r;
    hnd_nxt  = hnd_r;
    if (wr.add_en && selected) begin
      base_nxt = req.addr;
      len_nxt  = req.rsize;
      hnd_nxt  = req.hnd;
    end
    if (wr.del_en && selected) begin
      len_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 32'd0;
      len_r  <= 32'd0;
    end else begin
      base_r <= base_nxt;
      len_r  <= len_nxt;
    end
  end

  // Handler reaches the output only from a slot that add has written
  always_ff @(posedge clk) begin
    hnd_r <= hnd_nxt;
  end

endmodule
